// ===== rtl/tlrq_pkg.sv =====
// ----------------------------------------------------------------------------
// tlrq_pkg
// Shared widths, request codes and channel payload types of the two-level
// task ready queue.
// ----------------------------------------------------------------------------
`default_nettype none

package tlrq_pkg;

	localparam int NUM_TASKS_DEF = 16;
	localparam int TICK_BITS_DEF = 16;

	localparam int REQ_W     = 3;
	localparam int ACTOR_W   = 4;
	localparam int TIMEOUT_W = 16;
	localparam int EXP_W     = 5;

	localparam logic [REQ_W-1:0] REQ_ENQ     = 3'd0;
	localparam logic [REQ_W-1:0] REQ_DEQ     = 3'd1;
	localparam logic [REQ_W-1:0] REQ_BLOCK   = 3'd2;
	localparam logic [REQ_W-1:0] REQ_UNBLOCK = 3'd3;
	localparam logic [REQ_W-1:0] REQ_TICK    = 3'd4;
	localparam logic [REQ_W-1:0] REQ_ARM     = 3'd5;
	localparam logic [REQ_W-1:0] REQ_WOKE    = 3'd6;

	typedef struct packed {
		logic [REQ_W-1:0]     req_type;
		logic [ACTOR_W-1:0]   actor_id;
		logic                 high_priority;
		logic [TIMEOUT_W-1:0] timeout_ticks;
	} req_t;

	typedef struct packed {
		logic               status;
		logic               granted_valid;
		logic [ACTOR_W-1:0] granted_actor;
		logic               woke_flag;
		logic [EXP_W-1:0]   expired_count;
	} rsp_t;

endpackage

`default_nettype wire

// ===== rtl/tlrq_chan_if.sv =====
// ----------------------------------------------------------------------------
// tlrq_chan_if
// Valid/ready channel carrying one request or one response payload.
// ----------------------------------------------------------------------------
`default_nettype none

interface tlrq_chan_if #(
	parameter type payload_t = logic
);

	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);

endinterface

`default_nettype wire

// ===== rtl/two_level_task_ready_queue_top.sv =====
// ----------------------------------------------------------------------------
// two_level_task_ready_queue_top
// Enqueue, block, unblock, arm and read-woke requests pass through ST_FIN
// to a registered response; a dequeue from a non-empty queue first passes
// ST_DEQ for the link memory read. A tick walks the timeout memory one task
// per cycle, then ST_DRAIN. One request is in work at a time, and a new
// one is accepted while the previous response waits in the output register.
// Reset clears all queues, marks and timeouts at once; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module two_level_task_ready_queue_top #(
	parameter int NUM_TASKS = tlrq_pkg::NUM_TASKS_DEF,
	parameter int TICK_BITS = tlrq_pkg::TICK_BITS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	tlrq_chan_if.sink    req,
	tlrq_chan_if.source  rsp
);

	localparam int IDW = $clog2(NUM_TASKS);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_DEQ   = 3'd1;
	localparam logic [2:0] ST_TICK  = 3'd2;
	localparam logic [2:0] ST_DRAIN = 3'd3;
	localparam logic [2:0] ST_FIN   = 3'd4;

	logic [2:0]           st_q;
	logic [NUM_TASKS-1:0] queued_q;
	logic [NUM_TASKS-1:0] blocked_q;
	logic [NUM_TASKS-1:0] woke_q;
	logic [NUM_TASKS-1:0] armed_q;
	logic [IDW-1:0]       hi_head_q;
	logic [IDW-1:0]       hi_tail_q;
	logic [IDW-1:0]       lo_head_q;
	logic [IDW-1:0]       lo_tail_q;
	logic                 hi_ne_q;
	logic                 lo_ne_q;
	logic                 deq_hi_q;
	logic [IDW-1:0]       wk_q;
	logic                 tk_vld_s1;
	logic [IDW-1:0]       tk_idx_s1;
	logic                 out_vld_q;
	tlrq_pkg::rsp_t       res_q;
	tlrq_pkg::rsp_t       out_q;
	tlrq_pkg::rsp_t       acc_res;

	logic [IDW-1:0]       link_mem [NUM_TASKS];
	logic [TICK_BITS-1:0] tick_mem [NUM_TASKS];
	logic [IDW-1:0]       link_rd_q;
	logic [TICK_BITS-1:0] tick_rd_q;

	logic                 accept;
	logic                 id_ok;
	logic [IDW-1:0]       aid;
	logic [TICK_BITS-1:0] tv;
	logic [TICK_BITS-1:0] tk_cur;
	logic [TICK_BITS-1:0] tk_dec;
	logic                 tk_live;
	logic                 tk_exp;
	logic                 link_req;
	logic                 link_do;
	logic                 link_high;
	logic [IDW-1:0]       link_id;
	logic                 nl_we;
	logic [IDW-1:0]       nl_waddr;
	logic [IDW-1:0]       nl_raddr;
	logic                 tm_we;
	logic [IDW-1:0]       tm_addr;
	logic [TICK_BITS-1:0] tm_wdata;
	logic [IDW-1:0]       deq_id;
	logic                 out_load;

	assign req.ready = (st_q == ST_IDLE);
	assign accept    = req.valid && req.ready;
	assign aid       = IDW'(req.data.actor_id);
	assign id_ok     = (int'({1'b0, req.data.actor_id}) < NUM_TASKS);
	assign tv        = TICK_BITS'(req.data.timeout_ticks);

	assign tk_cur  = armed_q[tk_idx_s1] ? tick_rd_q : '0;
	assign tk_dec  = tk_cur - TICK_BITS'(1);
	assign tk_live = tk_vld_s1 && (tk_cur != '0);
	assign tk_exp  = tk_live && (tk_dec == '0);

	assign deq_id   = deq_hi_q ? hi_head_q : lo_head_q;
	assign out_load = (st_q == ST_FIN) && (!out_vld_q || rsp.ready);

	always_comb begin
		link_req  = 1'b0;
		link_id   = aid;
		link_high = 1'b1;
		if (tk_exp) begin
			link_req  = 1'b1;
			link_id   = tk_idx_s1;
			link_high = 1'b0;
		end else if (accept && id_ok) begin
			if (req.data.req_type == tlrq_pkg::REQ_ENQ) begin
				link_req  = 1'b1;
				link_high = req.data.high_priority;
			end else if (req.data.req_type == tlrq_pkg::REQ_UNBLOCK && blocked_q[aid]) begin
				link_req = 1'b1;
			end
		end
	end

	assign link_do  = link_req && !queued_q[link_id];
	assign nl_we    = link_do && (link_high ? hi_ne_q : lo_ne_q);
	assign nl_waddr = link_high ? hi_tail_q : lo_tail_q;
	assign nl_raddr = hi_ne_q ? hi_head_q : lo_head_q;

	assign tm_we    = tk_live || (accept && id_ok && req.data.req_type == tlrq_pkg::REQ_ARM);
	assign tm_addr  = tk_live ? tk_idx_s1 : aid;
	assign tm_wdata = tk_live ? tk_dec : tv;

	always_comb begin
		acc_res = '0;
		unique case (req.data.req_type)
			tlrq_pkg::REQ_ENQ: begin
				acc_res.status = id_ok && queued_q[aid];
			end
			tlrq_pkg::REQ_UNBLOCK: begin
				acc_res.status = id_ok && blocked_q[aid] && queued_q[aid];
			end
			tlrq_pkg::REQ_WOKE: begin
				acc_res.woke_flag = id_ok && woke_q[aid];
			end
			default: begin
				acc_res = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (nl_we) begin
			link_mem[nl_waddr] <= link_id;
		end
		link_rd_q <= link_mem[nl_raddr];
		if (tm_we) begin
			tick_mem[tm_addr] <= tm_wdata;
		end
		tick_rd_q <= tick_mem[wk_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= ST_IDLE;
			queued_q  <= '0;
			blocked_q <= '0;
			woke_q    <= '0;
			armed_q   <= '0;
			hi_head_q <= '0;
			hi_tail_q <= '0;
			lo_head_q <= '0;
			lo_tail_q <= '0;
			hi_ne_q   <= 1'b0;
			lo_ne_q   <= 1'b0;
			deq_hi_q  <= 1'b0;
			wk_q      <= '0;
			tk_vld_s1 <= 1'b0;
			tk_idx_s1 <= '0;
			out_vld_q <= 1'b0;
		end else begin
			tk_vld_s1 <= (st_q == ST_TICK);
			tk_idx_s1 <= wk_q;
			if (link_do) begin
				queued_q[link_id] <= 1'b1;
				if (link_high) begin
					if (!hi_ne_q) begin
						hi_head_q <= link_id;
					end
					hi_tail_q <= link_id;
					hi_ne_q   <= 1'b1;
				end else begin
					if (!lo_ne_q) begin
						lo_head_q <= link_id;
					end
					lo_tail_q <= link_id;
					lo_ne_q   <= 1'b1;
				end
			end
			if (tk_exp) begin
				woke_q[tk_idx_s1] <= 1'b1;
			end
			if (out_vld_q && rsp.ready && !out_load) begin
				out_vld_q <= 1'b0;
			end
			unique case (st_q)
				ST_IDLE: begin
					if (accept) begin
						unique case (req.data.req_type)
							tlrq_pkg::REQ_DEQ: begin
								deq_hi_q <= hi_ne_q;
								st_q     <= (hi_ne_q || lo_ne_q) ? ST_DEQ : ST_FIN;
							end
							tlrq_pkg::REQ_BLOCK: begin
								st_q <= ST_FIN;
								if (id_ok) begin
									blocked_q[aid] <= 1'b1;
								end
							end
							tlrq_pkg::REQ_UNBLOCK: begin
								st_q <= ST_FIN;
								if (id_ok) begin
									blocked_q[aid] <= 1'b0;
								end
							end
							tlrq_pkg::REQ_TICK: begin
								wk_q <= '0;
								st_q <= ST_TICK;
							end
							tlrq_pkg::REQ_ARM: begin
								st_q <= ST_FIN;
								if (id_ok) begin
									armed_q[aid] <= 1'b1;
								end
							end
							tlrq_pkg::REQ_WOKE: begin
								st_q <= ST_FIN;
								if (id_ok) begin
									woke_q[aid] <= 1'b0;
								end
							end
							default: begin
								st_q <= ST_FIN;
							end
						endcase
					end
				end
				ST_DEQ: begin
					queued_q[deq_id] <= 1'b0;
					if (deq_hi_q) begin
						if (hi_head_q == hi_tail_q) begin
							hi_ne_q <= 1'b0;
						end else begin
							hi_head_q <= link_rd_q;
						end
					end else begin
						if (lo_head_q == lo_tail_q) begin
							lo_ne_q <= 1'b0;
						end else begin
							lo_head_q <= link_rd_q;
						end
					end
					st_q <= ST_FIN;
				end
				ST_TICK: begin
					if (wk_q == IDW'(NUM_TASKS - 1)) begin
						st_q <= ST_DRAIN;
					end else begin
						wk_q <= wk_q + IDW'(1);
					end
				end
				ST_DRAIN: begin
					st_q <= ST_FIN;
				end
				ST_FIN: begin
					if (out_load) begin
						out_vld_q <= 1'b1;
						st_q      <= ST_IDLE;
					end
				end
				default: begin
					st_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_q <= acc_res;
		end else if (st_q == ST_DEQ) begin
			res_q.granted_valid <= 1'b1;
			res_q.granted_actor <= tlrq_pkg::ACTOR_W'(deq_id);
		end else if (tk_exp) begin
			res_q.expired_count <= res_q.expired_count + tlrq_pkg::EXP_W'(1);
			if (queued_q[tk_idx_s1]) begin
				res_q.status <= 1'b1;
			end
		end
		if (out_load) begin
			out_q <= res_q;
		end
	end

	assign rsp.valid = out_vld_q;
	assign rsp.data  = out_q;

	a_empty_none_queued: assert property (@(posedge clk) disable iff (!arst_n)
		(!hi_ne_q && !lo_ne_q) |-> (queued_q == '0))
		else $error("Both queues are empty but a task is still marked queued.");

	a_deq_head_queued: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_DEQ) |-> queued_q[deq_id])
		else $error("Dequeue removes a head task that is not marked queued.");

	a_walk_from_tick: assert property (@(posedge clk) disable iff (!arst_n)
		tk_vld_s1 |-> ($past(st_q) == ST_TICK))
		else $error("Timeout counter processed outside of a tick walk.");

endmodule

`default_nettype wire
